### rtl/core/rcc_pkg.sv
`default_nettype none

package rcc_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COEF_BITS_DEF = 8;
    localparam int KSIZE         = 3;
    localparam int KERNEL_CENTER = 9;
    localparam int CHAN_MAX      = 255;
    localparam int DEF_WIDTH     = 1024;
    localparam int DEF_HEIGHT    = 1024;
    localparam int PDATA_W       = 32;

    // Tags that travel with one result through the arithmetic pipeline.
    typedef struct packed {
        logic last_of_run;
        logic frame_done;
    } t_tag;

    // Window row or column index of an edge-replicated neighbor position.
    function automatic logic [1:0] tap_idx(input logic signed [17:0] pos,
                                           input logic signed [17:0] hi,
                                           input logic signed [17:0] base);
        logic signed [17:0] pc;
        logic signed [17:0] d;
        pc = (pos < 18'sd0) ? 18'sd0 : ((pos > hi) ? hi : pos);
        d  = pc - base + 18'sd2;
        if (d < 18'sd0) begin
            return 2'd0;
        end else if (d > 18'sd2) begin
            return 2'd2;
        end
        return d[1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/rcc_linebuf.sv
`default_nettype none

module rcc_linebuf #(
    parameter int DEPTH = rcc_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(rcc_pkg::MAX_WIDTH_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [63:0]   o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [63:0]   i_wr_data
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_q;
    logic        r_fwd;
    logic [63:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // A read that meets a write to the same entry takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

`default_nettype wire

### rtl/core/rcc_mac.sv
`default_nettype none

module rcc_mac #(
    parameter int COEF_BITS = rcc_pkg::COEF_BITS_DEF,
    parameter int CW        = $clog2(rcc_pkg::MAX_WIDTH_DEF)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_v,
    output logic                        o_rdy,
    input  wire logic [31:0]            i_taps [rcc_pkg::KSIZE*rcc_pkg::KSIZE],
    input  wire logic [3*COEF_BITS-1:0] i_coef [rcc_pkg::KSIZE],
    input  wire logic [15:0]            i_row,
    input  wire logic [CW-1:0]          i_col,
    input  wire rcc_pkg::t_tag          i_tag,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [7:0]                  o_red,
    output logic [7:0]                  o_green,
    output logic [7:0]                  o_blue,
    output logic [7:0]                  o_alpha,
    output logic [15:0]                 o_row,
    output logic [CW-1:0]               o_col,
    output logic                        o_last_of_run,
    output logic                        o_frame_done
);

    localparam int K  = rcc_pkg::KSIZE;
    localparam int PW = COEF_BITS + 9;
    localparam int RW = PW + 2;
    localparam int SW = PW + 4;

    logic r_vt, r_vm, r_va, r_vo;
    logic rdy_t, rdy_m, rdy_a, rdy_o;

    logic [31:0]          r_taps [K*K];
    logic [15:0]          r_row_t, r_row_m, r_row_a;
    logic [CW-1:0]        r_col_t, r_col_m, r_col_a;
    rcc_pkg::t_tag        r_tag_t, r_tag_m, r_tag_a;
    logic [7:0]           r_alp_m, r_alp_a;
    logic signed [PW-1:0] r_prod [3][K*K];
    logic signed [RW-1:0] r_rsum [3][K];
    logic signed [PW-1:0] prod   [3][K*K];
    logic signed [RW-1:0] rsum   [3][K];
    logic signed [SW-1:0] tsum   [3];
    logic [7:0]           clamped [3];
    logic [7:0]           r_out   [3];

    assign rdy_o = !r_vo || !i_stall;
    assign rdy_a = !r_va || rdy_o;
    assign rdy_m = !r_vm || rdy_a;
    assign rdy_t = !r_vt || rdy_m;
    assign o_rdy = rdy_t;

    always_comb begin
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] b;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < K*K; k++) begin
                a = PW'($signed({1'b0, r_taps[k][8*ch +: 8]}));
                b = PW'($signed(i_coef[k/K][(k%K)*COEF_BITS +: COEF_BITS]));
                prod[ch][k] = a * b;
            end
            for (int ky = 0; ky < K; ky++) begin
                rsum[ch][ky] = RW'(r_prod[ch][ky*K]) + RW'(r_prod[ch][ky*K+1])
                             + RW'(r_prod[ch][ky*K+2]);
            end
            tsum[ch] = SW'(r_rsum[ch][0]) + SW'(r_rsum[ch][1]) + SW'(r_rsum[ch][2]);
            if (tsum[ch] < 0) begin
                clamped[ch] = 8'd0;
            end else if (tsum[ch] > SW'(rcc_pkg::CHAN_MAX)) begin
                clamped[ch] = 8'(rcc_pkg::CHAN_MAX);
            end else begin
                clamped[ch] = tsum[ch][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt <= 1'b0;
            r_vm <= 1'b0;
            r_va <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy_t) r_vt <= i_v;
            if (rdy_m) r_vm <= r_vt;
            if (rdy_a) r_va <= r_vm;
            if (rdy_o) r_vo <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_t && i_v) begin
            r_taps  <= i_taps;
            r_row_t <= i_row;
            r_col_t <= i_col;
            r_tag_t <= i_tag;
        end
        if (rdy_m && r_vt) begin
            r_prod  <= prod;
            r_row_m <= r_row_t;
            r_col_m <= r_col_t;
            r_tag_m <= r_tag_t;
            r_alp_m <= r_taps[(K*K)/2][31:24];
        end
        if (rdy_a && r_vm) begin
            r_rsum  <= rsum;
            r_row_a <= r_row_m;
            r_col_a <= r_col_m;
            r_tag_a <= r_tag_m;
            r_alp_a <= r_alp_m;
        end
        if (rdy_o && r_va) begin
            r_out         <= clamped;
            o_alpha       <= r_alp_a;
            o_row         <= r_row_a;
            o_col         <= r_col_a;
            o_last_of_run <= r_tag_a.last_of_run;
            o_frame_done  <= r_tag_a.frame_done;
        end
    end

    assign o_valid = r_vo;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule

`default_nettype wire

### rtl/core/rgb_convolution_3x3_clamp_top.sv
// Path: an accepted item passes stage 1, the window sequencer and the MAC's tap, product,
// row-sum and output registers. The sequencer issues one result per cycle while the MAC
// is ready; an item with k results (up to four) holds it until all k have left.
// Reset (i_rst_n, synchronous, active low) clears all valid flags, the row and column
// counters and the registers to their defaults; the line memories are not cleared
// and need no clearing pass, since edge replication never reads a stale entry.
`default_nettype none

module rgb_convolution_3x3_clamp_top #(
    parameter int MAX_WIDTH = rcc_pkg::MAX_WIDTH_DEF,
    parameter int COEF_BITS = rcc_pkg::COEF_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Pixel input channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [7:0]                 i_red,
    input  wire logic [7:0]                 i_green,
    input  wire logic [7:0]                 i_blue,
    input  wire logic [7:0]                 i_alpha,
    // Result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [7:0]                      o_red,
    output logic [7:0]                      o_green,
    output logic [7:0]                      o_blue,
    output logic [7:0]                      o_alpha,
    output logic [15:0]                     o_row,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_col,
    output logic                            o_last_of_run,
    output logic                            o_frame_done,
    // Register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [4:0]                 paddr,
    input  wire logic [rcc_pkg::PDATA_W-1:0] pwdata,
    output logic [rcc_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int K   = rcc_pkg::KSIZE;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int XW  = (WW > 11) ? WW : 11;
    localparam int CFW = 3 * COEF_BITS;
    localparam int DW  = rcc_pkg::PDATA_W;

    localparam logic [COEF_BITS-1:0] NEG_ONE = '1;
    localparam logic [CFW-1:0] COEF_EDGE_DEF = {NEG_ONE, NEG_ONE, NEG_ONE};
    localparam logic [CFW-1:0] COEF_MID_DEF  =
        {NEG_ONE, COEF_BITS'(rcc_pkg::KERNEL_CENTER), NEG_ONE};

    typedef enum logic [2:0] {
        REG_COEF_TOP,
        REG_COEF_MID,
        REG_COEF_BOT,
        REG_WIDTH,
        REG_HEIGHT
    } t_reg;

    // ------------------------------------------------------------------
    // Registers. User writes only while the block is idle, not enforced.
    // ------------------------------------------------------------------
    logic [CFW-1:0] r_coef [K];
    logic [10:0]    r_width;
    logic [15:0]    r_height;
    logic           cfg_wr;
    logic [63:0]    wdata_ext;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign wdata_ext = 64'(pwdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= COEF_EDGE_DEF;
            r_coef[1] <= COEF_MID_DEF;
            r_coef[2] <= COEF_EDGE_DEF;
            r_width   <= 11'(rcc_pkg::DEF_WIDTH);
            r_height  <= 16'(rcc_pkg::DEF_HEIGHT);
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[4:2]))
                REG_COEF_TOP: r_coef[0] <= wdata_ext[CFW-1:0];
                REG_COEF_MID: r_coef[1] <= wdata_ext[CFW-1:0];
                REG_COEF_BOT: r_coef[2] <= wdata_ext[CFW-1:0];
                REG_WIDTH:    r_width   <= pwdata[10:0];
                REG_HEIGHT:   r_height  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[4:2]))
            REG_COEF_TOP: prdata = DW'(r_coef[0]);
            REG_COEF_MID: prdata = DW'(r_coef[1]);
            REG_COEF_BOT: prdata = DW'(r_coef[2]);
            REG_WIDTH:    prdata = DW'(r_width);
            REG_HEIGHT:   prdata = DW'(r_height);
            default:      prdata = '0;
        endcase
    end

    // Image size in use: width held to 1..MAX_WIDTH, zero height read as one.
    logic [XW-1:0] w_raw, eff_w, w_last;
    logic [15:0]   eff_h, h_last;

    always_comb begin
        w_raw = XW'(r_width);
        if (w_raw == '0) begin
            eff_w = XW'(1);
        end else if (w_raw > XW'(MAX_WIDTH)) begin
            eff_w = XW'(MAX_WIDTH);
        end else begin
            eff_w = w_raw;
        end
        w_last = eff_w - XW'(1);
        eff_h  = (r_height == '0) ? 16'd1 : r_height;
        h_last = eff_h - 16'd1;
    end

    // ------------------------------------------------------------------
    // Handshake chain. Each stage loads when it is empty or moving on.
    // ------------------------------------------------------------------
    logic r_v1, r_vs;
    logic rdy_1, rdy_seq, rdy_mac;
    logic seq_done, accept;

    assign rdy_1   = !r_v1 || rdy_seq;
    assign o_stall = !rdy_1;
    assign accept  = i_valid && rdy_1;

    // ------------------------------------------------------------------
    // Raster position. A counter left beyond the image by a register change
    // restarts at zero before the item is taken.
    // ------------------------------------------------------------------
    logic [CW-1:0] r_col, c_eff;
    logic [15:0]   r_row, row_eff;

    assign c_eff   = (XW'(r_col) >= eff_w) ? '0 : r_col;
    assign row_eff = (r_row >= eff_h) ? 16'd0 : r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (XW'(c_eff) == w_last) begin
                r_col <= '0;
                r_row <= (row_eff == h_last) ? 16'd0 : row_eff + 16'd1;
            end else begin
                r_col <= c_eff + CW'(1);
                r_row <= row_eff;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the item waits in a register for the line memory read. The memory
    // entry holds the pixel one row above in its low word and two rows above
    // in its high word; the entry is rewritten as the item moves on.
    // ------------------------------------------------------------------
    logic [31:0]   r_px1;
    logic [CW-1:0] r_col1;
    logic [15:0]   r_row1;
    logic [63:0]   lb_rd;
    logic          lb_wr;

    assign lb_wr = r_v1 && rdy_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy_1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px1  <= {i_alpha, i_blue, i_green, i_red};
            r_col1 <= c_eff;
            r_row1 <= row_eff;
        end
    end

    rcc_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (c_eff),
        .o_rd_data (lb_rd),
        .i_wr_en   (lb_wr),
        .i_wr_addr (r_col1),
        .i_wr_data ({lb_rd[31:0], r_px1})
    );

    // ------------------------------------------------------------------
    // Window and result sequencer. The 3x3 window shifts left by one column
    // per item. Up to four results are due, one per slot: bit 0 and bit 1
    // are the row above (previous column, then the right edge when the item
    // ends its row), bits 2 and 3 the same columns of the current row when
    // the item lies in the bottom row. One slot leaves per cycle while the
    // MAC is ready, lowest first.
    // ------------------------------------------------------------------
    logic [31:0]   r_win [K*K];
    logic [15:0]   r_rs;
    logic [CW-1:0] r_cs;
    logic [3:0]    r_mask;
    logic [3:0]    mask_new;
    logic [1:0]    slot;
    logic          emit;
    logic          mask_single;

    logic                 wl1, hl1, rg1, cg1;
    assign wl1 = (XW'(r_col1) == w_last);
    assign hl1 = (r_row1 == h_last);
    assign rg1 = (r_row1 != 16'd0);
    assign cg1 = (r_col1 != '0);
    assign mask_new = {hl1 && wl1, hl1 && cg1, rg1 && wl1, rg1 && cg1};

    assign mask_single = ((r_mask & (r_mask - 4'd1)) == 4'd0);
    assign emit        = r_vs && (r_mask != 4'd0) && rdy_mac;
    assign seq_done    = r_vs && ((r_mask == 4'd0) || (mask_single && rdy_mac));
    assign rdy_seq     = !r_vs || seq_done;

    always_comb begin
        priority if (r_mask[0]) begin
            slot = 2'd0;
        end else if (r_mask[1]) begin
            slot = 2'd1;
        end else if (r_mask[2]) begin
            slot = 2'd2;
        end else begin
            slot = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs   <= 1'b0;
            r_mask <= '0;
        end else if (lb_wr) begin
            r_vs   <= 1'b1;
            r_mask <= mask_new;
        end else if (seq_done) begin
            r_vs   <= 1'b0;
            r_mask <= '0;
        end else if (emit) begin
            r_mask <= r_mask & (r_mask - 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (lb_wr) begin
            for (int i = 0; i < K; i++) begin
                r_win[i*K]   <= r_win[i*K+1];
                r_win[i*K+1] <= r_win[i*K+2];
            end
            r_win[2]     <= lb_rd[63:32];
            r_win[K+2]   <= lb_rd[31:0];
            r_win[2*K+2] <= r_px1;
            r_rs         <= r_row1;
            r_cs         <= r_col1;
        end
    end

    // Position of the result in the current slot and its edge-replicated taps.
    logic [15:0]        ey;
    logic [CW-1:0]      ex;
    logic [31:0]        taps [K*K];
    logic [1:0]         ri [K];
    logic [1:0]         ci [K];
    rcc_pkg::t_tag      tag;

    assign ey = slot[1] ? r_rs : r_rs - 16'd1;
    assign ex = slot[0] ? r_cs : r_cs - CW'(1);

    always_comb begin
        for (int k = 0; k < K; k++) begin
            ri[k] = rcc_pkg::tap_idx(18'($signed({2'b00, ey})) + 18'(k) - 18'sd1,
                                     18'($signed({2'b00, h_last})),
                                     18'($signed({2'b00, r_rs})));
            ci[k] = rcc_pkg::tap_idx(18'($signed({1'b0, ex})) + 18'(k) - 18'sd1,
                                     18'($signed({1'b0, w_last})),
                                     18'($signed({1'b0, r_cs})));
        end
        for (int ky = 0; ky < K; ky++) begin
            for (int kx = 0; kx < K; kx++) begin
                taps[ky*K+kx] = r_win[4'(ri[ky]) * 4'd3 + 4'(ci[kx])];
            end
        end
        tag.last_of_run = mask_single;
        tag.frame_done  = (ey == h_last) && (XW'(ex) == w_last);
    end

    // ------------------------------------------------------------------
    // Multiply, row sums, total and clamp, with the output register last.
    // ------------------------------------------------------------------
    rcc_mac #(
        .COEF_BITS (COEF_BITS),
        .CW        (CW)
    ) u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_v           (emit),
        .o_rdy         (rdy_mac),
        .i_taps        (taps),
        .i_coef        (r_coef),
        .i_row         (ey),
        .i_col         (ex),
        .i_tag         (tag),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_row         (o_row),
        .o_col         (o_col),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("input stalled with an empty first stage");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted item did not reach the first stage");

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> r_vs && (r_mask != 4'd0))
        else $error("result issued with no pending slot");

    a_seq_holds_memory_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vs && !seq_done && r_v1) |-> !lb_wr)
        else $error("line memory written while the sequencer is busy");

endmodule

`default_nettype wire

### tb/tb_rgb_convolution_3x3_clamp_top.sv
`default_nettype none

// Testbench for the streaming 3x3 RGBA convolution block.
// A driver process feeds pixel items from a queue in random bursts, and a
// monitor process checks every result item against a local prediction of the
// window, line buffers, edge replication, clamping and row/column tagging.
// Registers are written over the APB-style port only while the block is idle.
module tb_rgb_convolution_3x3_clamp_top;

    localparam int MAXW = rcc_pkg::MAX_WIDTH_DEF;

    // Register indexes; the byte address is four times the index.
    typedef enum int {
        REG_COEF_TOP = 0,
        REG_COEF_MID = 1,
        REG_COEF_BOT = 2,
        REG_WIDTH    = 3,
        REG_HEIGHT   = 4
    } t_reg_idx;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] row;
        logic [9:0]  col;
        logic        last_of_run;
        logic        frame_done;
    } t_filtered;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic [7:0]  i_alpha = '0;

    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [15:0] o_row;
    logic [9:0]  o_col;
    logic        o_last_of_run;
    logic        o_frame_done;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rgb_convolution_3x3_clamp_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_alpha       (i_alpha),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_row         (o_row),
        .o_col         (o_col),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // Local copy of the block's registers and state.
    logic [23:0] kern_row [3];
    logic [10:0] img_width;
    logic [15:0] img_height;
    logic [31:0] line_up1 [MAXW];
    logic [31:0] line_up2 [MAXW];
    logic [31:0] win [9];
    int unsigned row_pos;
    int unsigned col_pos;

    t_pixel    pixel_q[$];
    t_filtered filtered_q[$];

    int n_errors = 0;
    int n_pixels = 0;
    int n_filtered = 0;
    int n_frames = 0;
    int n_configs = 0;

    function automatic int unsigned used_width();
        if (img_width == 0) begin
            return 1;
        end
        if (img_width > MAXW) begin
            return MAXW;
        end
        return img_width;
    endfunction

    function automatic int unsigned used_height();
        return (img_height == 0) ? 1 : img_height;
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Window tap for absolute position (y, x), replicated at the image edges.
    // The window spans rows r-2..r and columns c-2..c.
    function automatic logic [31:0] tap(int r, int c, int y, int x);
        int yy;
        int xx;
        yy = clip(y, 0, int'(used_height()) - 1);
        xx = clip(x, 0, int'(used_width()) - 1);
        return win[clip(yy - r + 2, 0, 2) * 3 + clip(xx - c + 2, 0, 2)];
    endfunction

    function automatic t_filtered filter_at(int r, int c, int y, int x);
        t_filtered f;
        int acc [3];
        logic [31:0] p;
        int wgt;
        acc = '{0, 0, 0};
        for (int ky = 0; ky < 3; ky++) begin
            for (int kx = 0; kx < 3; kx++) begin
                p = tap(r, c, y + ky - 1, x + kx - 1);
                wgt = $signed(kern_row[ky][8*kx +: 8]);
                for (int ch = 0; ch < 3; ch++) begin
                    acc[ch] += int'(p[8*ch +: 8]) * wgt;
                end
            end
        end
        f.red = 8'(clip(acc[0], 0, rcc_pkg::CHAN_MAX));
        f.green = 8'(clip(acc[1], 0, rcc_pkg::CHAN_MAX));
        f.blue = 8'(clip(acc[2], 0, rcc_pkg::CHAN_MAX));
        p = tap(r, c, y, x);
        f.alpha = p[31:24];
        f.row = 16'(y);
        f.col = 10'(x);
        f.last_of_run = 1'b0;
        f.frame_done = (y == int'(used_height()) - 1) && (x == int'(used_width()) - 1);
        return f;
    endfunction

    // Advances the local state by one accepted pixel and queues its results.
    task automatic convolve_pixel(input t_pixel px);
        int unsigned w;
        int unsigned h;
        int r;
        int c;
        int n;
        logic [31:0] packed_px;
        w = used_width();
        h = used_height();
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        packed_px = {px.alpha, px.blue, px.green, px.red};
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3 + 1];
            win[i*3 + 1] = win[i*3 + 2];
        end
        win[2] = line_up2[col_pos];
        win[5] = line_up1[col_pos];
        win[8] = packed_px;
        line_up2[col_pos] = line_up1[col_pos];
        line_up1[col_pos] = packed_px;
        r = row_pos;
        c = col_pos;
        n = 0;
        // The row above finishes first; the last row of the frame flushes itself.
        for (int y = r - 1; y <= r; y++) begin
            if (y < 0) continue;
            if (y == r && r != int'(h) - 1) continue;
            if (c >= 1) begin
                filtered_q.push_back(filter_at(r, c, y, c - 1));
                n++;
            end
            if (c == int'(w) - 1) begin
                filtered_q.push_back(filter_at(r, c, y, c));
                n++;
            end
        end
        if (n > 0) filtered_q[filtered_q.size() - 1].last_of_run = 1'b1;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, n_filtered, got, want);
        n_errors++;
    endtask

    // Pixel driver: bursts of random length with random gaps between them.
    int burst_left = 0;
    int gap_left = 0;
    t_pixel next_px;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                convolve_pixel('{i_red, i_green, i_blue, i_alpha});
                n_pixels++;
            end
            // A stalled item must stay on the bus unchanged.
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    next_px = pixel_q.pop_front();
                    i_red <= next_px.red;
                    i_green <= next_px.green;
                    i_blue <= next_px.blue;
                    i_alpha <= next_px.alpha;
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: a rotating pattern, plus one long hold-off that lets the
    // block fill and push back on its input.
    int stall_cycle = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit hold_req = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && hold_req) begin
            hold_done = 1'b1;
            hold_left = 400;
            i_stall <= 1'b1;
        end else begin
            stall_cycle++;
            case ((stall_cycle >> 6) % 4)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= stall_cycle[2];
            endcase
        end
    end

    // Result monitor.
    t_filtered want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (filtered_q.size() == 0) begin
                report("unexpected result item row", o_row, -1);
            end else begin
                want = filtered_q.pop_front();
                if (o_red !== want.red) report("red", o_red, want.red);
                if (o_green !== want.green) report("green", o_green, want.green);
                if (o_blue !== want.blue) report("blue", o_blue, want.blue);
                if (o_alpha !== want.alpha) report("alpha", o_alpha, want.alpha);
                if (o_row !== want.row) report("row", o_row, want.row);
                if (o_col !== want.col) report("col", o_col, want.col);
                if (o_last_of_run !== want.last_of_run) begin
                    report("last_of_run", o_last_of_run, want.last_of_run);
                end
                if (o_frame_done !== want.frame_done) begin
                    report("frame_done", o_frame_done, want.frame_done);
                end
                if (want.frame_done) n_frames++;
            end
            n_filtered++;
        end
    end

    // One APB write: setup cycle, then access cycle.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(int'(idx) * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COEF_TOP: kern_row[0] = value[23:0];
            REG_COEF_MID: kern_row[1] = value[23:0];
            REG_COEF_BOT: kern_row[2] = value[23:0];
            REG_WIDTH:    img_width = value[10:0];
            default:      img_height = value[15:0];
        endcase
        n_configs++;
    endtask

    task automatic set_image(input int w, input int h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic set_kernel(input logic [31:0] t, input logic [31:0] m,
                              input logic [31:0] b);
        write_reg(REG_COEF_TOP, t);
        write_reg(REG_COEF_MID, m);
        write_reg(REG_COEF_BOT, b);
    endtask

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
        pixel_q.push_back('{r, g, b, a});
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) begin
            push_pixel($urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // Waits until every pixel is taken and every result has come, then lets
    // the pipeline drain, since pixels on the first row cause no result.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_q.size() > 0 || i_valid || filtered_q.size() > 0);
        repeat (20) @(negedge i_clk);
    endtask

    int rand_pixels;
    int w;
    int h;
    int frames;

    initial begin
        kern_row[0] = 24'hFFFFFF;
        kern_row[1] = 24'hFF09FF;
        kern_row[2] = 24'hFFFFFF;
        img_width = 11'(rcc_pkg::DEF_WIDTH);
        img_height = 16'(rcc_pkg::DEF_HEIGHT);
        foreach (win[i]) win[i] = '0;
        row_pos = 0;
        col_pos = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default 1024 x 1024 image: the first pixels of row 0 give no result.
        push_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
        push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
        wait_idle();

        // Zero width and height act as a one-pixel image; each pixel is its own
        // frame. The column left over from the default image restarts at zero.
        set_kernel(32'hFF_7F8080, 32'h00_80_7F_80, 32'h12_7F807F);
        set_image(0, 0);
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'h80, 8'h7F, 8'h01, 8'hA5);
        wait_idle();

        // 3 x 3 image with the sharpen kernel: corners, edges and one interior.
        set_kernel(32'h00FFFFFF, 32'h00FF09FF, 32'h00FFFFFF);
        set_image(3, 3);
        for (int i = 0; i < 9; i++) begin
            push_pixel((i % 2) ? 8'hFF : 8'h00, 8'(i * 29), (i % 3 == 0) ? 8'hFF : 8'h10,
                       8'(i));
        end
        wait_idle();

        // Oversized width is held to the maximum; shrinking the width afterwards
        // leaves the column counter inside the row, so it carries on.
        set_image(2047, 65535);
        push_random(2);
        wait_idle();
        set_image(3, 2);
        push_random(6);
        wait_idle();

        // Shrinking the height below the current row restarts the row counter.
        set_image(2, 3);
        push_random(4);
        wait_idle();
        write_reg(REG_HEIGHT, 1);
        push_random(2);
        wait_idle();

        // Long hold-off on the result side while a whole frame is offered, so
        // the block fills up and stalls its input.
        set_image(8, 5);
        hold_req = 1'b1;
        push_random(40);
        wait_idle();

        // Random part: whole frames of small images with random kernels.
        rand_pixels = 0;
        while (rand_pixels < 120) begin
            set_kernel($urandom, $urandom, $urandom);
            case ($urandom_range(0, 7))
                0: w = 0;
                1: w = 1;
                2: w = $urandom_range(7, 12);
                default: w = $urandom_range(2, 6);
            endcase
            h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
            set_image(w, h);
            frames = $urandom_range(1, 2);
            w = (w == 0) ? 1 : w;
            h = (h == 0) ? 1 : h;
            push_random(frames * w * h);
            rand_pixels += frames * w * h;
            wait_idle();
        end

        $display("Covered %0d pixel items and %0d result items over %0d register writes,",
                 n_pixels, n_filtered, n_configs);
        $display("including %0d complete frames, edge replication and clamping extremes.",
                 n_frames);
        if (n_errors == 0 && filtered_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/core/rcc_pkg.sv
rtl/core/rcc_linebuf.sv
rtl/core/rcc_mac.sv
rtl/core/rgb_convolution_3x3_clamp_top.sv
tb/tb_rgb_convolution_3x3_clamp_top.sv
